// File: src/clnw_pkg.sv
// ----------------------------------------------------------------------------
// clnw_pkg
// Shared types and constants for the character LCD nibble writer.
// ----------------------------------------------------------------------------
package clnw_pkg;

  localparam logic [7:0] PulseTicksReset = 8'd10;
  localparam int unsigned QueueDepthDefault = 2;

  typedef enum logic {
    ActTick  = 1'b0,
    ActWrite = 1'b1
  } action_e;

  typedef enum logic [8:0] {
    PhIdle    = 9'b000000001,
    PhHiEn    = 9'b000000010,
    PhHiGap   = 9'b000000100,
    PhLoEn    = 9'b000001000,
    PhLoGap   = 9'b000010000,
    PhPollEn1 = 9'b000100000,
    PhPollGp1 = 9'b001000000,
    PhPollEn2 = 9'b010000000,
    PhPollGp2 = 9'b100000000
  } phase_e;

  // Classified request handed from the front end to the sequencer.
  typedef struct packed {
    action_e    action;
    logic [7:0] byte_value;
    logic       is_data;
    logic       busy_line;
  } req_t;

  // Pin levels and status reported after one item.
  typedef struct packed {
    logic       rs_pin;
    logic       rw_pin;
    logic       en_pin;
    logic [3:0] bus_nibble;
    logic       bus_drive;
    logic       idle;
    logic       accepted;
  } res_t;

endpackage

// File: src/clnw_queue.sv
// ----------------------------------------------------------------------------
// clnw_queue
// Small register-based first-in first-out queue with push/full, pop/empty.
// ----------------------------------------------------------------------------
module clnw_queue #(
  parameter int unsigned Depth = 2,
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: src/clnw_front.sv
// ----------------------------------------------------------------------------
// clnw_front
// Input register stage: takes items from the port and classifies them.
// ----------------------------------------------------------------------------
module clnw_front
  import clnw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic       action_i,
  input  logic [7:0] byte_value_i,
  input  logic       is_data_i,
  input  logic       busy_line_i,
  output logic       req_valid_o,
  output req_t       req_o,
  input  logic       req_full_i
);

  logic valid_q, valid_d;
  req_t req_q;
  logic take;

  // The stage holds one item; it refills in the cycle it hands one on.
  assign full_o = valid_q && req_full_i;
  assign take   = push_i && !full_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (!req_full_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q.action     <= action_i ? ActWrite : ActTick;
      req_q.byte_value <= byte_value_i;
      req_q.is_data    <= is_data_i;
      req_q.busy_line  <= busy_line_i;
    end
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

endmodule

// File: src/clnw_back.sv
// ----------------------------------------------------------------------------
// clnw_back
// Pin sequencer: LCD write, busy poll; one item per cycle unless stalled.
// ----------------------------------------------------------------------------
module clnw_back
  import clnw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       req_empty_i,
  input  req_t       req_i,
  output logic       req_pop_o,
  input  logic       res_full_i,
  output logic       res_push_o,
  output res_t       res_o
);

  logic [7:0] pulse_ticks_q;
  phase_e     phase_q, phase_d;
  logic [7:0] count_q, count_d;
  logic [7:0] held_byte_q, held_byte_d;
  logic       held_sel_q, held_sel_d;
  logic       busy_seen_q, busy_seen_d;
  logic       step;
  logic       is_idle;
  logic [7:0] count_inc;
  logic       pulse_end;
  logic       acc;

  assign cfg_ready_o = 1'b1;
  assign step        = !req_empty_i && !res_full_i;
  assign req_pop_o   = step;
  assign res_push_o  = step;

  assign count_inc = count_q + 8'd1;
  // A pulse length of zero ends the pulse on its first tick, same as one.
  assign pulse_end = (count_inc >= pulse_ticks_q);

  always_comb begin
    unique case (phase_q)
      PhHiEn, PhHiGap, PhLoEn, PhLoGap,
      PhPollEn1, PhPollGp1, PhPollEn2, PhPollGp2: is_idle = 1'b0;
      default:                                     is_idle = 1'b1;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    held_byte_d = held_byte_q;
    held_sel_d  = held_sel_q;
    busy_seen_d = busy_seen_q;
    acc         = 1'b0;
    if (req_i.action == ActWrite) begin
      if (is_idle) begin
        held_byte_d = req_i.byte_value;
        held_sel_d  = req_i.is_data;
        busy_seen_d = 1'b0;
        phase_d     = PhHiEn;
        count_d     = '0;
        acc         = 1'b1;
      end
    end else begin
      unique case (phase_q)
        PhHiEn: begin
          count_d = count_inc;
          if (pulse_end) begin
            phase_d = PhHiGap;
            count_d = '0;
          end
        end
        PhHiGap: begin
          phase_d = PhLoEn;
          count_d = '0;
        end
        PhLoEn: begin
          count_d = count_inc;
          if (pulse_end) begin
            phase_d = PhLoGap;
            count_d = '0;
          end
        end
        PhLoGap: begin
          phase_d = PhPollEn1;
          count_d = '0;
        end
        PhPollEn1: begin
          count_d = count_inc;
          if (pulse_end) begin
            busy_seen_d = req_i.busy_line;
            phase_d     = PhPollGp1;
            count_d     = '0;
          end
        end
        PhPollGp1: begin
          phase_d = PhPollEn2;
          count_d = '0;
        end
        PhPollEn2: begin
          count_d = count_inc;
          if (pulse_end) begin
            phase_d = PhPollGp2;
            count_d = '0;
          end
        end
        PhPollGp2: begin
          phase_d = busy_seen_q ? PhPollEn1 : PhIdle;
          count_d = '0;
        end
        default: begin
          phase_d = PhIdle;
          count_d = '0;
        end
      endcase
    end
  end

  // Pin levels follow the phase after this step.
  always_comb begin
    res_o            = '0;
    res_o.bus_drive  = 1'b1;
    res_o.accepted   = acc;
    unique case (phase_d)
      PhHiEn, PhHiGap: begin
        res_o.rs_pin     = held_sel_d;
        res_o.bus_nibble = held_byte_d[7:4];
        res_o.en_pin     = (phase_d == PhHiEn);
      end
      PhLoEn, PhLoGap: begin
        res_o.rs_pin     = held_sel_d;
        res_o.bus_nibble = held_byte_d[3:0];
        res_o.en_pin     = (phase_d == PhLoEn);
      end
      PhPollEn1, PhPollGp1, PhPollEn2, PhPollGp2: begin
        res_o.rw_pin    = 1'b1;
        res_o.bus_drive = 1'b0;
        res_o.en_pin    = (phase_d == PhPollEn1) || (phase_d == PhPollEn2);
      end
      default: begin
        res_o.idle = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_ticks_q <= PulseTicksReset;
      phase_q       <= PhIdle;
      count_q       <= '0;
      held_sel_q    <= 1'b0;
      busy_seen_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        pulse_ticks_q <= cfg_data_i;
      end
      if (step) begin
        phase_q     <= phase_d;
        count_q     <= count_d;
        held_sel_q  <= held_sel_d;
        busy_seen_q <= busy_seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      held_byte_q <= held_byte_d;
    end
  end

endmodule

// File: src/char_lcd_nibble_writer.sv
// A result is registered in the input stage, the request queue and the result
// queue. Throughput: the sequencer retires one tick or request per cycle while
// the request queue holds an item and the result queue has room.
// Reset (rst_ni low, asynchronous) empties both queues, sets the sequencer
// idle and the enable pulse length to 10 ticks.
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// Character LCD writer over a 4-bit bus with busy-flag polling.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer
  import clnw_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       action_i,
  input  logic [7:0] byte_value_i,
  input  logic       is_data_i,
  input  logic       busy_line_i,
  output logic       empty,
  input  logic       pop,
  output logic       rs_pin_o,
  output logic       rw_pin_o,
  output logic       en_pin_o,
  output logic [3:0] bus_nibble_o,
  output logic       bus_drive_o,
  output logic       idle_o,
  output logic       accepted_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic req_valid, req_full, req_empty, req_pop;
  req_t front_req, queued_req;
  logic res_push, res_full;
  res_t back_res, out_res;

  clnw_front u_front (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .full_o       (full),
    .action_i,
    .byte_value_i,
    .is_data_i,
    .busy_line_i,
    .req_valid_o  (req_valid),
    .req_o        (front_req),
    .req_full_i   (req_full)
  );

  clnw_queue #(
    .Depth  (QueueDepth),
    .item_t (req_t)
  ) u_req_queue (
    .clk_i,
    .rst_ni,
    .push_i  (req_valid),
    .item_i  (front_req),
    .full_o  (req_full),
    .pop_i   (req_pop),
    .item_o  (queued_req),
    .empty_o (req_empty)
  );

  clnw_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .req_empty_i (req_empty),
    .req_i       (queued_req),
    .req_pop_o   (req_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  clnw_queue #(
    .Depth  (QueueDepth),
    .item_t (res_t)
  ) u_res_queue (
    .clk_i,
    .rst_ni,
    .push_i  (res_push),
    .item_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .item_o  (out_res),
    .empty_o (empty)
  );

  assign rs_pin_o     = out_res.rs_pin;
  assign rw_pin_o     = out_res.rw_pin;
  assign en_pin_o     = out_res.en_pin;
  assign bus_nibble_o = out_res.bus_nibble;
  assign bus_drive_o  = out_res.bus_drive;
  assign idle_o       = out_res.idle;
  assign accepted_o   = out_res.accepted;

endmodule

// File: verif/char_lcd_nibble_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_tb
// Streams ticks and write requests into the LCD nibble writer and checks
// the pin levels reported for every item against a cycle-free predictor.
// Several enable pulse lengths are used, including zero and the maximum.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_tb
  import clnw_pkg::*;
;

  // Predicts the pin levels that follow each accepted item and checks the
  // levels the block reports, oldest first.
  class lcd_pin_scoreboard;
    logic [7:0] pulse_ticks;
    phase_e     phase;
    logic [7:0] pulse_count;
    logic [7:0] held_byte;
    logic       held_select;
    logic       busy_seen;
    res_t       pins_due[$];
    int         errors;

    function new();
      pulse_ticks = PulseTicksReset;
      phase       = PhIdle;
      pulse_count = '0;
      held_byte   = '0;
      held_select = 1'b0;
      busy_seen   = 1'b0;
      errors      = 0;
    endfunction

    function void set_pulse_ticks(logic [7:0] v);
      pulse_ticks = v;
    endfunction

    function bit is_idle();
      return phase == PhIdle;
    endfunction

    function int pending();
      return pins_due.size();
    endfunction

    function void enter(phase_e p);
      phase       = p;
      pulse_count = '0;
    endfunction

    // A pulse of zero length behaves like one tick, which the compare gives.
    function bit pulse_done();
      pulse_count = pulse_count + 8'd1;
      return pulse_count >= pulse_ticks;
    endfunction

    function void advance_tick(logic busy_line);
      case (phase)
        PhHiEn:    if (pulse_done()) enter(PhHiGap);
        PhHiGap:   enter(PhLoEn);
        PhLoEn:    if (pulse_done()) enter(PhLoGap);
        PhLoGap:   enter(PhPollEn1);
        PhPollEn1: begin
          if (pulse_done()) begin
            busy_seen = busy_line;
            enter(PhPollGp1);
          end
        end
        PhPollGp1: enter(PhPollEn2);
        PhPollEn2: if (pulse_done()) enter(PhPollGp2);
        PhPollGp2: enter(busy_seen ? PhPollEn1 : PhIdle);
        default:   enter(PhIdle);
      endcase
    endfunction

    function void take_item(req_t it);
      res_t r;
      r = '0;
      if (it.action == ActWrite) begin
        if (phase == PhIdle) begin
          held_byte   = it.byte_value;
          held_select = it.is_data;
          busy_seen   = 1'b0;
          enter(PhHiEn);
          r.accepted  = 1'b1;
        end
      end else begin
        advance_tick(it.busy_line);
      end
      r.bus_drive = 1'b1;
      case (phase)
        PhHiEn, PhHiGap: begin
          r.rs_pin     = held_select;
          r.bus_nibble = held_byte[7:4];
          r.en_pin     = (phase == PhHiEn);
        end
        PhLoEn, PhLoGap: begin
          r.rs_pin     = held_select;
          r.bus_nibble = held_byte[3:0];
          r.en_pin     = (phase == PhLoEn);
        end
        PhPollEn1, PhPollGp1, PhPollEn2, PhPollGp2: begin
          r.rw_pin    = 1'b1;
          r.bus_drive = 1'b0;
          r.en_pin    = (phase == PhPollEn1) || (phase == PhPollEn2);
        end
        default: ;
      endcase
      r.idle = (phase == PhIdle);
      pins_due.push_back(r);
    endfunction

    function void compare_field(string what, logic [3:0] exp_v, logic [3:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, got_v);
      end
    endfunction

    function void check_pins(res_t got);
      res_t want;
      if (pins_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        return;
      end
      want = pins_due.pop_front();
      compare_field("rs_pin", 4'(want.rs_pin), 4'(got.rs_pin));
      compare_field("rw_pin", 4'(want.rw_pin), 4'(got.rw_pin));
      compare_field("en_pin", 4'(want.en_pin), 4'(got.en_pin));
      compare_field("bus_nibble", want.bus_nibble, got.bus_nibble);
      compare_field("bus_drive", 4'(want.bus_drive), 4'(got.bus_drive));
      compare_field("idle", 4'(want.idle), 4'(got.idle));
      compare_field("accepted", 4'(want.accepted), 4'(got.accepted));
    endfunction
  endclass

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       push         = 1'b0;
  logic       full;
  logic       action_i     = 1'b0;
  logic [7:0] byte_value_i = '0;
  logic       is_data_i    = 1'b0;
  logic       busy_line_i  = 1'b0;
  logic       empty;
  logic       pop          = 1'b0;
  logic       rs_pin_o;
  logic       rw_pin_o;
  logic       en_pin_o;
  logic [3:0] bus_nibble_o;
  logic       bus_drive_o;
  logic       idle_o;
  logic       accepted_o;
  logic       cfg_valid_i  = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i   = '0;

  lcd_pin_scoreboard pin_sb;
  int items_sent = 0;
  bit gaps_on    = 1'b0;

  char_lcd_nibble_writer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .action_i     (action_i),
    .byte_value_i (byte_value_i),
    .is_data_i    (is_data_i),
    .busy_line_i  (busy_line_i),
    .empty        (empty),
    .pop          (pop),
    .rs_pin_o     (rs_pin_o),
    .rw_pin_o     (rw_pin_o),
    .en_pin_o     (en_pin_o),
    .bus_nibble_o (bus_nibble_o),
    .bus_drive_o  (bus_drive_o),
    .idle_o       (idle_o),
    .accepted_o   (accepted_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // The result side stalls at random, except over a long window of items.
  always @(negedge clk_i) begin
    pop <= (items_sent >= 100 && items_sent < 220) || ($urandom_range(99) >= 9);
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && pop && !empty) begin
      got.rs_pin     = rs_pin_o;
      got.rw_pin     = rw_pin_o;
      got.en_pin     = en_pin_o;
      got.bus_nibble = bus_nibble_o;
      got.bus_drive  = bus_drive_o;
      got.idle       = idle_o;
      got.accepted   = accepted_o;
      pin_sb.check_pins(got);
    end
  end

  // Push stays high between items, bar random gaps; release_input lowers it.
  task automatic send_item(action_e act, logic [7:0] b, logic d, logic busy);
    req_t it;
    it.action     = act;
    it.byte_value = b;
    it.is_data    = d;
    it.busy_line  = busy;
    @(negedge clk_i);
    while (gaps_on && !(items_sent >= 250 && items_sent < 380) &&
           $urandom_range(99) < 9) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push         <= 1'b1;
    action_i     <= act;
    byte_value_i <= b;
    is_data_i    <= d;
    busy_line_i  <= busy;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pin_sb.take_item(it);
    items_sent++;
  endtask

  task automatic release_input();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  // Ticks until the write finishes; DB7 reads busy for the first ticks given.
  task automatic finish_write(int busy_ticks);
    int n;
    n = 0;
    while (!pin_sb.is_idle()) begin
      send_item(ActTick, 8'($urandom), 1'($urandom), n < busy_ticks);
      n++;
    end
  endtask

  task automatic random_burst(int count);
    for (int i = 0; i < count; i++) begin
      if (pin_sb.is_idle() ? ($urandom_range(99) < 85) : ($urandom_range(99) < 8))
        send_item(ActWrite, 8'($urandom), 1'($urandom), 1'($urandom));
      else
        send_item(ActTick, 8'($urandom), 1'($urandom), $urandom_range(99) < 25);
    end
  endtask

  // Lets every expected result drain before the register is touched.
  task automatic wait_drained();
    release_input();
    while (pin_sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_pulse_ticks(logic [7:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    pin_sb.set_pulse_ticks(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    pin_sb = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset pulse length first, with random traffic.
    gaps_on = 1'b1;
    random_burst(50);
    wait_drained();

    // Directed part with single-tick pulses.
    write_pulse_ticks(8'd1);
    send_item(ActTick, 8'hFF, 1'b1, 1'b1);
    send_item(ActWrite, 8'hFF, 1'b1, 1'b1);
    finish_write(5);
    send_item(ActWrite, 8'h00, 1'b0, 1'b0);
    send_item(ActWrite, 8'h5A, 1'b1, 1'b1);
    finish_write(0);
    send_item(ActWrite, 8'hA5, 1'b1, 1'b0);
    finish_write(0);
    wait_drained();

    // A zero pulse length behaves as one tick.
    write_pulse_ticks(8'd0);
    send_item(ActWrite, 8'h3C, 1'b0, 1'b0);
    finish_write(6);
    send_item(ActWrite, 8'hC3, 1'b1, 1'b1);
    finish_write(0);
    wait_drained();

    // The longest pulse is run for the high nibble only, up to the tick that
    // drops enable; the rest of the write uses single-tick pulses.
    write_pulse_ticks(8'd255);
    send_item(ActWrite, 8'h96, 1'b1, 1'b0);
    repeat (255) send_item(ActTick, 8'($urandom), 1'($urandom), 1'b0);
    wait_drained();
    write_pulse_ticks(8'd1);
    finish_write(0);
    wait_drained();

    write_pulse_ticks(8'($urandom_range(6, 2)));
    random_burst(35);
    wait_drained();

    write_pulse_ticks(8'd1);
    random_burst(35);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (pin_sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
